>>> sv/pps_pkg.sv
// pps_pkg: sizes, action codes and shared types of the priority scheduler
// used by pps_cell, preemptive_priority_scheduler_top and pps_checker
`default_nettype none
package pps_pkg;

	localparam int PROCESS_SLOTS = 16;
	localparam int BURST_BITS    = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int TIME_BITS     = 32;

	// port widths fixed by the word format
	localparam int SLOT_PORT_W  = 4;
	localparam int BURST_PORT_W = 16;
	localparam int PRIO_PORT_W  = 8;

	localparam int SLOT_IDX_W = $clog2(PROCESS_SLOTS);

	localparam logic ACT_ADMIT = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// best candidate handed from cell to cell during a scan
	typedef struct packed {
		logic                     found;
		logic [PRIORITY_BITS-1:0] prio;
		logic [TIME_BITS-1:0]     atime;
		logic [SLOT_IDX_W-1:0]    idx;
		logic                     first;
		logic                     fin;
	} cand_t;

	// admit data shared by all cells
	typedef struct packed {
		logic [BURST_BITS-1:0]    burst;
		logic [PRIORITY_BITS-1:0] prio;
		logic [TIME_BITS-1:0]     atime;
	} adm_t;

	// run strobe broadcast at the end of a scan
	typedef struct packed {
		logic                  run;
		logic [SLOT_IDX_W-1:0] idx;
	} upd_t;

endpackage
`default_nettype wire

>>> sv/preemptive_priority_scheduler_top.sv
// preemptive_priority_scheduler_top: preemptive priority scheduler over a row of slot cells
// depends on pps_pkg and pps_cell
//
// usage
//  - input channel (in_valid / in_ready) takes one word: action, slot, burst_time,
//    priority_level. an admit word loads a free slot and gives no result;
//    admits to an occupied slot, past the table or with a zero burst change nothing
//  - a tick word starts a scan: the best candidate walks the chain of PROCESS_SLOTS
//    cells, one cell per cycle, lowest priority number first, then earliest admit
//    time, then lowest slot index
//  - after the scan the winning cell is charged one time unit and the result word
//    (idle, slot_run, first_run, finished, time_now) goes to the output register
//  - out_valid rises when the scan has run the length of the cell chain and ST_DONE
//    has loaded the result word, and in_ready returns in the same cycle; no word is
//    taken during a scan. in_ready stays high after an admit, so admits can follow
//  - the output register holds one word; while it is full a new word is still taken,
//    and a finished scan waits in its last state until out_ready frees the register
//  - reset clears all slot valid and started flags, the time counter and out_valid;
//    slot payload registers are written on admit and need no reset
//  - time_now saturates at all ones
`default_nettype none
module preemptive_priority_scheduler_top
	import pps_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    action,
	input  wire logic [SLOT_PORT_W-1:0]  slot,
	input  wire logic [BURST_PORT_W-1:0] burst_time,
	input  wire logic [PRIO_PORT_W-1:0]  priority_level,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         idle,
	output logic [SLOT_PORT_W-1:0]       slot_run,
	output logic                         first_run,
	output logic                         finished,
	output logic [TIME_BITS-1:0]         time_now
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [SLOT_IDX_W-1:0]    cnt_q;
	logic [TIME_BITS-1:0]     time_q;
	logic [TIME_BITS-1:0]     time_nxt;
	logic                     out_valid_q;
	logic                     idle_q;
	logic [SLOT_PORT_W-1:0]   slot_run_q;
	logic                     first_run_q;
	logic                     finished_q;
	logic [TIME_BITS-1:0]     time_now_q;

	logic                     in_go;
	logic                     adm_go;
	logic                     tick_go;
	logic                     out_free;
	logic                     done_go;
	logic [BURST_BITS-1:0]    burst_in;
	logic [PRIORITY_BITS-1:0] prio_in;
	logic [PROCESS_SLOTS-1:0] adm_hit;
	adm_t                     adm;
	upd_t                     upd;
	cand_t                    chain [PROCESS_SLOTS+1];
	cand_t                    win;

	// handshake
	assign in_ready = (state_q == ST_IDLE);
	assign in_go    = in_valid && in_ready;
	assign tick_go  = in_go && (action == ACT_TICK);
	assign out_free = !out_valid_q || out_ready;
	assign done_go  = (state_q == ST_DONE) && out_free;

	// admit word: take the low bits the slot table keeps
	assign burst_in = BURST_BITS'({{BURST_BITS{1'b0}}, burst_time});
	assign prio_in  = PRIORITY_BITS'({{PRIORITY_BITS{1'b0}}, priority_level});
	assign adm_go   = in_go && (action == ACT_ADMIT) && (burst_in != '0);

	assign adm.burst = burst_in;
	assign adm.prio  = prio_in;
	assign adm.atime = time_q;

	// slot decode; slot numbers past the table hit nothing
	for (genvar i = 0; i < PROCESS_SLOTS; i++) begin : g_hit
		if (i < (1 << SLOT_PORT_W)) begin : g_dec
			assign adm_hit[i] = adm_go && (slot == SLOT_PORT_W'(i));
		end else begin : g_none
			assign adm_hit[i] = 1'b0;
		end
	end

	// the chain enters with no candidate
	assign chain[0] = '0;

	for (genvar i = 0; i < PROCESS_SLOTS; i++) begin : g_cell
		pps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (SLOT_IDX_W'(i)),
			.adm_hit  (adm_hit[i]),
			.adm      (adm),
			.upd      (upd),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1])
		);
	end

	// chain end holds the winner once the scan has run its length
	assign win = chain[PROCESS_SLOTS];

	// charge the winner when its result word is loaded
	assign upd.run = done_go && win.found;
	assign upd.idx = win.idx;

	// saturating time step
	assign time_nxt = (time_q == '1) ? time_q : time_q + TIME_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			time_q      <= '0;
			out_valid_q <= 1'b0;
			idle_q      <= 1'b0;
			slot_run_q  <= '0;
			first_run_q <= 1'b0;
			finished_q  <= 1'b0;
			time_now_q  <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_go) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					// one cell per cycle until the last cell holds the winner
					if (cnt_q == SLOT_IDX_W'(PROCESS_SLOTS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + SLOT_IDX_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						time_q      <= time_nxt;
						out_valid_q <= 1'b1;
						idle_q      <= !win.found;
						if (win.found) begin
							slot_run_q  <= SLOT_PORT_W'({{SLOT_PORT_W{1'b0}}, win.idx});
							first_run_q <= win.first;
							finished_q  <= win.fin;
						end else begin
							slot_run_q  <= '0;
							first_run_q <= 1'b0;
							finished_q  <= 1'b0;
						end
						time_now_q <= time_nxt;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign idle      = idle_q;
	assign slot_run  = slot_run_q;
	assign first_run = first_run_q;
	assign finished  = finished_q;
	assign time_now  = time_now_q;

endmodule
`default_nettype wire

>>> sv/pps_cell.sv
// pps_cell: one process slot of the scheduler chain
// holds the slot state and passes the better of its own slot and the incoming candidate on
`default_nettype none
module pps_cell
	import pps_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [SLOT_IDX_W-1:0] cell_idx,
	input  wire logic                  adm_hit,
	input  wire adm_t                  adm,
	input  wire upd_t                  upd,
	input  wire cand_t                 cand_in,
	output cand_t                      cand_out
);

	logic                     valid_q;
	logic                     started_q;
	logic [BURST_BITS-1:0]    rem_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [TIME_BITS-1:0]     atime_q;
	cand_t                    cand_q;
	cand_t                    cand_nxt;
	logic                     better;
	logic                     load;
	logic                     run_here;
	logic                     last_unit;

	assign load      = adm_hit && !valid_q;
	assign run_here  = upd.run && (upd.idx == cell_idx);
	assign last_unit = (rem_q == BURST_BITS'(1));

	// strict compares keep the lower index on a full tie
	always_comb begin
		better = valid_q && (!cand_in.found || (prio_q < cand_in.prio) ||
			((prio_q == cand_in.prio) && (atime_q < cand_in.atime)));
		if (better) begin
			cand_nxt.found = 1'b1;
			cand_nxt.prio  = prio_q;
			cand_nxt.atime = atime_q;
			cand_nxt.idx   = cell_idx;
			cand_nxt.first = !started_q;
			cand_nxt.fin   = last_unit;
		end else begin
			cand_nxt = cand_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			started_q <= 1'b0;
		end else if (load) begin
			valid_q   <= 1'b1;
			started_q <= 1'b0;
		end else if (run_here) begin
			valid_q   <= !last_unit;
			started_q <= !last_unit;
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= cand_nxt;
		if (load) begin
			rem_q   <= adm.burst;
			prio_q  <= adm.prio;
			atime_q <= adm.atime;
		end else if (run_here) begin
			rem_q <= rem_q - BURST_BITS'(1);
		end
	end

	assign cand_out = cand_q;

endmodule
`default_nettype wire

>>> sv/pps_checker.sv
// pps_checker: port-level assertions for preemptive_priority_scheduler_top
// depends on pps_pkg; bound to the top level below
`default_nettype none
module pps_checker
	import pps_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    action,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic                    idle,
	input wire logic [SLOT_PORT_W-1:0]  slot_run,
	input wire logic                    first_run,
	input wire logic                    finished,
	input wire logic [TIME_BITS-1:0]    time_now
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(time_now) && $stable(slot_run))
		else $error("result word changed while stalled");

	// an idle tick reports nothing about any slot
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle |-> (slot_run == '0) && !first_run && !finished)
		else $error("idle result carries slot data");

	// every tick advances time from zero, so a result never shows time zero
	a_time_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (time_now != '0))
		else $error("result with time zero");

	// a tick occupies the scan chain, so no word is taken in the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == ACT_TICK) |=> !in_ready)
		else $error("word taken during a scan");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.action    (action),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.idle      (idle),
	.slot_run  (slot_run),
	.first_run (first_run),
	.finished  (finished),
	.time_now  (time_now)
);
`default_nettype wire
